[sv/lfc_pkg.sv]
`default_nettype none

package lfc_pkg;

    localparam int POS_W    = 12;
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 24;
    localparam int SPEED_W  = 8;
    localparam int ERR_W    = 13;
    localparam int DER_W    = ERR_W + 1;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 8;

    // Signed product widths: the unsigned gain is widened by one sign bit.
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int PI_W   = SUM_W + GAIN_W + 1;
    localparam int PD_W   = DER_W + GAIN_W + 1;
    localparam int ACC_W  = PI_W + 1;
    localparam int MAG_W  = ACC_W - FRAC_W;

    localparam logic [POS_W-1:0] LINE_CENTER = POS_W'(2000);

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_BASE_SPEED = 3'd3,
        REG_THRESHOLD  = 3'd4,
        REG_DEADZONE   = 3'd5
    } t_reg_idx;

    localparam logic [GAIN_W-1:0]   RST_GAIN_P     = GAIN_W'(5120);
    localparam logic [GAIN_W-1:0]   RST_GAIN_I     = GAIN_W'(2560000);
    localparam logic [GAIN_W-1:0]   RST_GAIN_D     = GAIN_W'(384);
    localparam logic [SPEED_W-1:0]  RST_BASE_SPEED = SPEED_W'(150);
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD  = SAMPLE_W'(250);
    localparam logic [SAMPLE_W-1:0] RST_DEADZONE   = SAMPLE_W'(100);

    typedef struct packed {
        logic [POS_W-1:0]    line_pos;
        logic [SAMPLE_W-1:0] sample_far_left;
        logic [SAMPLE_W-1:0] sample_left;
        logic [SAMPLE_W-1:0] sample_middle;
        logic [SAMPLE_W-1:0] sample_right;
        logic [SAMPLE_W-1:0] sample_far_right;
        logic                restart;
    } t_in;

    typedef struct packed {
        logic               stop_event;
        logic [SPEED_W-1:0] drive_left;
        logic [SPEED_W-1:0] drive_right;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [SPEED_W-1:0]  base_speed;
        logic [SAMPLE_W-1:0] sense_threshold;
        logic [SAMPLE_W-1:0] sense_deadzone;
    } t_cfg;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        logic                    stop;
        logic                    restart;
        logic signed [ERR_W-1:0] err;
    } t_cls;

endpackage

`default_nettype wire

[sv/lfc_front.sv]
`default_nettype none

module lfc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lfc_pkg::t_in  i_in_data,
    input  wire lfc_pkg::t_cfg i_cfg,
    output logic               o_cls_valid,
    input  wire logic          i_cls_ready,
    output lfc_pkg::t_cls      o_cls_data
);

    logic          r_valid;
    lfc_pkg::t_cls r_data;
    lfc_pkg::t_cls n_data;
    logic          accept;
    logic [lfc_pkg::SAMPLE_W:0] lit_bound;
    logic          lit_far_left;
    logic          lit_far_right;
    logic          dark_left;
    logic          dark_middle;
    logic          dark_right;

    // A sample is dark when sample + deadzone < threshold; this form never wraps.
    function automatic logic is_dark(input logic [lfc_pkg::SAMPLE_W-1:0] s,
                                     input logic [lfc_pkg::SAMPLE_W-1:0] thr,
                                     input logic [lfc_pkg::SAMPLE_W-1:0] dz);
        logic [lfc_pkg::SAMPLE_W:0] lhs;
        lhs = {1'b0, s} + {1'b0, dz};
        return lhs < {1'b0, thr};
    endfunction

    assign o_in_stall = r_valid && !i_cls_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        lit_bound     = {1'b0, i_cfg.sense_threshold} + {1'b0, i_cfg.sense_deadzone};
        lit_far_left  = {1'b0, i_in_data.sample_far_left} >= lit_bound;
        lit_far_right = {1'b0, i_in_data.sample_far_right} >= lit_bound;
        dark_left     = is_dark(i_in_data.sample_left, i_cfg.sense_threshold,
                                i_cfg.sense_deadzone);
        dark_middle   = is_dark(i_in_data.sample_middle, i_cfg.sense_threshold,
                                i_cfg.sense_deadzone);
        dark_right    = is_dark(i_in_data.sample_right, i_cfg.sense_threshold,
                                i_cfg.sense_deadzone);
        n_data.stop    = lit_far_left || lit_far_right ||
                         (dark_left && dark_middle && dark_right);
        n_data.restart = i_in_data.restart;
        n_data.err     = $signed({1'b0, i_in_data.line_pos})
                         - $signed({1'b0, lfc_pkg::LINE_CENTER});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !i_cls_ready);
        end
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_cls_valid = r_valid;
    assign o_cls_data  = r_data;

endmodule

`default_nettype wire

[sv/lfc_queue.sv]
`default_nettype none

module lfc_queue #(
    parameter int DEPTH = lfc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire lfc_pkg::t_cls i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop,
    output lfc_pkg::t_cls      o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfc_pkg::t_cls    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue fill count did not follow a lone write");

endmodule

`default_nettype wire

[sv/lfc_back.sv]
`default_nettype none

module lfc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cls_valid,
    output logic               o_cls_pop,
    input  wire lfc_pkg::t_cls i_cls_data,
    input  wire lfc_pkg::t_cfg i_cfg,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lfc_pkg::t_out      o_out_data
);

    localparam int ERR_W   = lfc_pkg::ERR_W;
    localparam int DER_W   = lfc_pkg::DER_W;
    localparam int SUM_W   = lfc_pkg::SUM_W;
    localparam int ACC_W   = lfc_pkg::ACC_W;
    localparam int MAG_W   = lfc_pkg::MAG_W;
    localparam int SPEED_W = lfc_pkg::SPEED_W;

    // Controller history.
    logic signed [ERR_W-1:0] r_prev;
    logic signed [SUM_W-1:0] r_sum;

    // Stage A: history update.
    logic                    r_a_valid;
    logic                    r_a_stop;
    logic signed [ERR_W-1:0] r_a_err;
    logic signed [DER_W-1:0] r_a_deriv;
    logic signed [SUM_W-1:0] r_a_sum;
    // Stage B: products.
    logic                            r_b_valid;
    logic                            r_b_stop;
    logic signed [lfc_pkg::PP_W-1:0] r_b_pp;
    logic signed [lfc_pkg::PI_W-1:0] r_b_pi;
    logic signed [lfc_pkg::PD_W-1:0] r_b_pd;
    // Stage C: accumulate.
    logic                    r_c_valid;
    logic                    r_c_stop;
    logic signed [ACC_W-1:0] r_c_acc;
    // Stage D: magnitude and sign.
    logic             r_d_valid;
    logic             r_d_stop;
    logic             r_d_neg;
    logic [MAG_W-1:0] r_d_mag;
    // Output register.
    logic          r_out_valid;
    lfc_pkg::t_out r_out;

    logic                    adv;
    logic                    pop;
    logic signed [ERR_W-1:0] base_prev;
    logic signed [SUM_W-1:0] base_sum;
    logic signed [DER_W-1:0] n_deriv;
    logic signed [SUM_W:0]   wide_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [ACC_W-1:0]        acc_abs;
    logic [SPEED_W-1:0]      mag_clamped;
    lfc_pkg::t_out           n_out;

    assign adv       = !r_out_valid || !i_out_stall;
    assign pop       = adv && i_cls_valid;
    assign o_cls_pop = pop;

    always_comb begin
        base_prev = i_cls_data.restart ? '0 : r_prev;
        base_sum  = i_cls_data.restart ? '0 : r_sum;
        n_deriv   = DER_W'(i_cls_data.err) - DER_W'(base_prev);
        wide_sum  = (SUM_W + 1)'(base_sum) + (SUM_W + 1)'(i_cls_data.err);
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            n_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                    : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            n_sum = wide_sum[SUM_W-1:0];
        end
    end

    always_comb begin
        acc_abs = r_c_acc[ACC_W-1] ? ACC_W'(-r_c_acc) : ACC_W'(r_c_acc);
    end

    always_comb begin
        if ((|r_d_mag[MAG_W-1:SPEED_W]) || (r_d_mag[SPEED_W-1:0] > i_cfg.base_speed)) begin
            mag_clamped = i_cfg.base_speed;
        end else begin
            mag_clamped = r_d_mag[SPEED_W-1:0];
        end
        n_out.stop_event = r_d_stop;
        if (r_d_stop) begin
            n_out.drive_left  = '0;
            n_out.drive_right = '0;
        end else if (r_d_neg) begin
            n_out.drive_left  = i_cfg.base_speed - mag_clamped;
            n_out.drive_right = i_cfg.base_speed;
        end else begin
            n_out.drive_left  = i_cfg.base_speed;
            n_out.drive_right = i_cfg.base_speed - mag_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_sum       <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (pop) begin
                if (i_cls_data.stop) begin
                    r_prev <= base_prev;
                    r_sum  <= base_sum;
                end else begin
                    r_prev <= i_cls_data.err;
                    r_sum  <= n_sum;
                end
            end
            r_a_valid   <= pop;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_stop  <= i_cls_data.stop;
            r_a_err   <= i_cls_data.err;
            r_a_deriv <= n_deriv;
            r_a_sum   <= n_sum;

            r_b_stop <= r_a_stop;
            r_b_pp   <= r_a_err * $signed({1'b0, i_cfg.gain_p});
            r_b_pi   <= r_a_sum * $signed({1'b0, i_cfg.gain_i});
            r_b_pd   <= r_a_deriv * $signed({1'b0, i_cfg.gain_d});

            r_c_stop <= r_b_stop;
            r_c_acc  <= ACC_W'(r_b_pp) + ACC_W'(r_b_pi) + ACC_W'(r_b_pd);

            r_d_stop <= r_c_stop;
            r_d_neg  <= r_c_acc[ACC_W-1];
            r_d_mag  <= acc_abs[ACC_W-1:lfc_pkg::FRAC_W];

            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stop_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_event) |->
            (r_out.drive_left == '0 && r_out.drive_right == '0))
        else $error("stop result carries nonzero drive");

    a_stop_keeps_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_cls_data.stop && !i_cls_data.restart) |=>
            (r_sum == $past(r_sum) && r_prev == $past(r_prev)))
        else $error("stop request changed controller history");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_sum == $past(r_sum) && r_a_valid == $past(r_a_valid)))
        else $error("pipeline advanced under output stall");

endmodule

`default_nettype wire

[sv/pid_line_follow_controller_unit.sv]
`default_nettype none

// PID line-follow controller. Each request carries a line position (2000 is
// centered) and five reflectance samples; each request yields exactly one
// result, in order. A stop result (drives zero, history kept unless restart is
// set) is raised when an outer sensor is on or the three middle sensors are all
// off; otherwise the error drives a Q16.8 PID step whose correction, clamped to
// plus or minus base_speed, slows the wheel on the side of the turn. The block
// sustains one request per clock cycle while the output is not stalled: the
// history update (error sum with 32-bit saturation and last error) is computed
// combinationally from the queue head and registered on each pop, and all later
// work is pipelined. An accepted request passes the classifying front register,
// the queue, then history update, multiply, accumulate, magnitude and the output
// register. The queue lets the front keep taking requests while the output is
// stalled, until it is full. Configuration registers are written through the
// write channel with the request index of the register; they must only be
// written while the block holds no request in flight.
module pid_line_follow_controller_unit #(
    parameter int QUEUE_DEPTH = lfc_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire lfc_pkg::t_in                      i_in_data,
    // Result channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output lfc_pkg::t_out                          o_out_data,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lfc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lfc_pkg::t_cfg r_cfg;
    logic          cfg_write;

    logic          front_valid;
    logic          queue_ready;
    lfc_pkg::t_cls front_data;
    logic          queue_valid;
    logic          queue_pop;
    lfc_pkg::t_cls queue_data;

    // Writes are always taken; a request to an unknown index is dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= lfc_pkg::RST_GAIN_P;
            r_cfg.gain_i          <= lfc_pkg::RST_GAIN_I;
            r_cfg.gain_d          <= lfc_pkg::RST_GAIN_D;
            r_cfg.base_speed      <= lfc_pkg::RST_BASE_SPEED;
            r_cfg.sense_threshold <= lfc_pkg::RST_THRESHOLD;
            r_cfg.sense_deadzone  <= lfc_pkg::RST_DEADZONE;
        end else if (cfg_write) begin
            case (i_cfg_index)
                lfc_pkg::REG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data[lfc_pkg::GAIN_W-1:0];
                end
                lfc_pkg::REG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data[lfc_pkg::GAIN_W-1:0];
                end
                lfc_pkg::REG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data[lfc_pkg::GAIN_W-1:0];
                end
                lfc_pkg::REG_BASE_SPEED: begin
                    r_cfg.base_speed <= i_cfg_data[lfc_pkg::SPEED_W-1:0];
                end
                lfc_pkg::REG_THRESHOLD: begin
                    r_cfg.sense_threshold <= i_cfg_data[lfc_pkg::SAMPLE_W-1:0];
                end
                lfc_pkg::REG_DEADZONE: begin
                    r_cfg.sense_deadzone <= i_cfg_data[lfc_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front classifies each request (stop test and position error).
    lfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .o_cls_valid (front_valid),
        .i_cls_ready (queue_ready),
        .o_cls_data  (front_data)
    );

    // The queue decouples classification from the arithmetic pipeline.
    lfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_push_data  (front_data),
        .o_pop_valid  (queue_valid),
        .i_pop        (queue_pop),
        .o_pop_data   (queue_data)
    );

    // The back owns the controller history and produces the drive levels.
    lfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (queue_valid),
        .o_cls_pop   (queue_pop),
        .i_cls_data  (queue_data),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[tb/tb_pid_line_follow_controller_unit.sv]
module tb_pid_line_follow_controller_unit;

    // Self-checking bench for the PID line-follow controller. A directed list
    // of requests comes first. Rows whose result is obvious carry it typed in;
    // the rest, and everything after, are checked against a behavioral
    // predictor of the controller kept in this module. Random phases then
    // sweep the register settings, extremes included. The last phase streams
    // off-center requests at full rate with no idling on either side.

    localparam int POS_W      = lfc_pkg::POS_W;
    localparam int SAMPLE_W   = lfc_pkg::SAMPLE_W;
    localparam int GAIN_W     = lfc_pkg::GAIN_W;
    localparam int SPEED_W    = lfc_pkg::SPEED_W;
    localparam int ERR_W      = lfc_pkg::ERR_W;
    localparam int SUM_W      = lfc_pkg::SUM_W;
    localparam int FRAC_W     = lfc_pkg::FRAC_W;
    localparam int CFG_IDX_W  = lfc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = lfc_pkg::CFG_DATA_W;

    typedef lfc_pkg::t_in      t_in;
    typedef lfc_pkg::t_out     t_out;
    typedef lfc_pkg::t_reg_idx t_reg_idx;

    // Sample levels used by the directed rows.
    localparam logic [SAMPLE_W-1:0] DARK   = '0;
    localparam logic [SAMPLE_W-1:0] BRIGHT = '1;

    localparam int RANDOM_ITEMS  = 90;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 40;
    localparam int FINAL_ITEMS   = 40;
    localparam int UNWIND_ITEMS  = 20;

    // One row of the directed list. When has_want is set, want is the result
    // that the row must produce; otherwise the predictor supplies it.
    typedef struct packed {
        t_in  req;
        logic has_want;
        t_out want;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register copies as the controller should hold them.
    logic [GAIN_W-1:0]   cfg_gain_p    = lfc_pkg::RST_GAIN_P;
    logic [GAIN_W-1:0]   cfg_gain_i    = lfc_pkg::RST_GAIN_I;
    logic [GAIN_W-1:0]   cfg_gain_d    = lfc_pkg::RST_GAIN_D;
    logic [SPEED_W-1:0]  cfg_speed     = lfc_pkg::RST_BASE_SPEED;
    logic [SAMPLE_W-1:0] cfg_threshold = lfc_pkg::RST_THRESHOLD;
    logic [SAMPLE_W-1:0] cfg_deadzone  = lfc_pkg::RST_DEADZONE;

    // PID history as the controller should hold it.
    logic signed [ERR_W-1:0] last_error = '0;
    logic signed [SUM_W-1:0] error_sum  = '0;

    // Drive results still owed by the controller, oldest first.
    t_out     pending_drives[$];
    t_dir_row directed_rows[$];

    int mismatch_count = 0;
    bit in_idle_en     = 1'b0;
    bit out_idle_en    = 1'b0;
    bit hold_off_req   = 1'b0;

    pid_line_follow_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Computes the drive result of one request and advances the PID history,
    // exactly as the controller must. All arithmetic is done in 64 bits,
    // which holds the largest product sum (2^31 * 2^24 plus the other terms)
    // without loss.
    function automatic t_out predict_drive(t_in req);
        t_out   res;
        longint lit_lvl;
        longint dark_lvl;
        longint err;
        longint deriv;
        longint sum;
        longint acc;
        longint corr;
        longint spd;
        logic   stop;
        res = '0;
        // Restart clears the history even when this request turns out to be
        // a stop.
        if (req.restart) begin
            last_error = '0;
            error_sum  = '0;
        end
        // The bounds are formed in signed 64-bit arithmetic, so a deadzone
        // wider than the threshold gives a negative dark bound and no sample
        // is ever dark.
        lit_lvl  = longint'(cfg_threshold) + longint'(cfg_deadzone);
        dark_lvl = longint'(cfg_threshold) - longint'(cfg_deadzone);
        stop = (longint'(req.sample_far_left) >= lit_lvl) ||
               (longint'(req.sample_far_right) >= lit_lvl) ||
               ((longint'(req.sample_left) < dark_lvl) &&
                (longint'(req.sample_middle) < dark_lvl) &&
                (longint'(req.sample_right) < dark_lvl));
        if (stop) begin
            res.stop_event = 1'b1;
            return res;
        end
        err   = longint'(req.line_pos) - longint'(lfc_pkg::LINE_CENTER);
        deriv = err - longint'(last_error);
        sum   = longint'(error_sum) + err;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
        end
        error_sum  = sum[SUM_W-1:0];
        last_error = err[ERR_W-1:0];
        acc = err * longint'(cfg_gain_p) + sum * longint'(cfg_gain_i) +
              deriv * longint'(cfg_gain_d);
        // Drop the fraction bits, rounding toward zero on both signs.
        if (acc < 0) begin
            corr = -((-acc) >>> FRAC_W);
        end else begin
            corr = acc >>> FRAC_W;
        end
        spd = longint'(cfg_speed);
        if (corr > spd) begin
            corr = spd;
        end
        if (corr < -spd) begin
            corr = -spd;
        end
        // The wheel on the side of the turn slows down.
        if (corr < 0) begin
            res.drive_left  = SPEED_W'(spd + corr);
            res.drive_right = SPEED_W'(spd);
        end else begin
            res.drive_left  = SPEED_W'(spd);
            res.drive_right = SPEED_W'(spd - corr);
        end
        return res;
    endfunction

    function automatic t_dir_row dir_row(int pos, int fl, int l, int m, int r, int fr,
                                         bit rst, bit has, bit stop, int dl, int dr);
        t_dir_row row;
        row.req.line_pos         = POS_W'(pos);
        row.req.sample_far_left  = SAMPLE_W'(fl);
        row.req.sample_left      = SAMPLE_W'(l);
        row.req.sample_middle    = SAMPLE_W'(m);
        row.req.sample_right     = SAMPLE_W'(r);
        row.req.sample_far_right = SAMPLE_W'(fr);
        row.req.restart          = rst;
        row.has_want             = has;
        row.want.stop_event      = stop;
        row.want.drive_left      = SPEED_W'(dl);
        row.want.drive_right     = SPEED_W'(dr);
        return row;
    endfunction

    // Picks a sample that favors the decision edges of the current setting.
    function automatic logic [SAMPLE_W-1:0] edge_sample(longint lit_lvl, longint dark_lvl);
        longint v;
        case ($urandom_range(0, 6))
            0: v = 0;
            1: v = 4095;
            2: v = lit_lvl;
            3: v = lit_lvl - 1;
            4: v = dark_lvl;
            5: v = dark_lvl - 1;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return SAMPLE_W'(v);
    endfunction

    // Most random requests see the line properly (no outer sensor on, some
    // middle sensor not off) so that the PID history keeps evolving; the
    // rest are noise around the on and off bounds, which often stops.
    function automatic t_in random_request();
        t_in    req;
        longint lit_lvl;
        longint dark_lvl;
        longint far_hi;
        longint mid_lo;
        lit_lvl  = longint'(cfg_threshold) + longint'(cfg_deadzone);
        dark_lvl = longint'(cfg_threshold) - longint'(cfg_deadzone);
        if ($urandom_range(0, 9) == 0) begin
            req.line_pos = POS_W'($urandom_range(4001, 4095));
        end else begin
            req.line_pos = POS_W'($urandom_range(0, 4000));
        end
        req.restart = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 9) < 7) begin
            far_hi = (lit_lvl > 4096) ? 4095 : lit_lvl - 1;
            if (far_hi < 0) begin
                // Every level counts as on here, so the request stops anyway.
                req.sample_far_left  = SAMPLE_W'($urandom);
                req.sample_far_right = SAMPLE_W'($urandom);
            end else begin
                req.sample_far_left  = SAMPLE_W'($urandom_range(0, int'(far_hi)));
                req.sample_far_right = SAMPLE_W'($urandom_range(0, int'(far_hi)));
            end
            req.sample_left   = SAMPLE_W'($urandom);
            req.sample_middle = SAMPLE_W'($urandom);
            req.sample_right  = SAMPLE_W'($urandom);
            if (dark_lvl <= 4095) begin
                mid_lo = (dark_lvl < 0) ? 0 : dark_lvl;
                case ($urandom_range(0, 2))
                    0: req.sample_left = SAMPLE_W'($urandom_range(int'(mid_lo), 4095));
                    1: req.sample_middle = SAMPLE_W'($urandom_range(int'(mid_lo), 4095));
                    default: req.sample_right = SAMPLE_W'($urandom_range(int'(mid_lo), 4095));
                endcase
            end
        end else begin
            req.sample_far_left  = edge_sample(lit_lvl, dark_lvl);
            req.sample_left      = edge_sample(lit_lvl, dark_lvl);
            req.sample_middle    = edge_sample(lit_lvl, dark_lvl);
            req.sample_right     = edge_sample(lit_lvl, dark_lvl);
            req.sample_far_right = edge_sample(lit_lvl, dark_lvl);
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Writes all six registers in index order. Bits above a narrow register's
    // width carry random junk, which the controller must ignore.
    task automatic load_settings(input int unsigned gp, input int unsigned gi,
                                 input int unsigned gd, input int unsigned spd,
                                 input int unsigned thr, input int unsigned dz);
        logic [CFG_DATA_W-1:0] word;
        t_reg_idx              idx;
        for (int k = lfc_pkg::REG_GAIN_P; k <= lfc_pkg::REG_DEADZONE; k++) begin
            idx  = t_reg_idx'(k);
            word = CFG_DATA_W'($urandom);
            case (idx)
                lfc_pkg::REG_GAIN_P:     word = CFG_DATA_W'(gp);
                lfc_pkg::REG_GAIN_I:     word = CFG_DATA_W'(gi);
                lfc_pkg::REG_GAIN_D:     word = CFG_DATA_W'(gd);
                lfc_pkg::REG_BASE_SPEED: word[SPEED_W-1:0] = SPEED_W'(spd);
                lfc_pkg::REG_THRESHOLD:  word[SAMPLE_W-1:0] = SAMPLE_W'(thr);
                default:                 word[SAMPLE_W-1:0] = SAMPLE_W'(dz);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= word;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                lfc_pkg::REG_GAIN_P:     cfg_gain_p = word[GAIN_W-1:0];
                lfc_pkg::REG_GAIN_I:     cfg_gain_i = word[GAIN_W-1:0];
                lfc_pkg::REG_GAIN_D:     cfg_gain_d = word[GAIN_W-1:0];
                lfc_pkg::REG_BASE_SPEED: cfg_speed = word[SPEED_W-1:0];
                lfc_pkg::REG_THRESHOLD:  cfg_threshold = word[SAMPLE_W-1:0];
                default:                 cfg_deadzone = word[SAMPLE_W-1:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one request and holds it until the controller takes it. The
    // expected result is queued at acceptance, so it sees the history left
    // by every earlier request.
    task automatic send_request(input t_in req, input logic has_want, input t_out want);
        t_out pred;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_drive(req);
        pending_drives.push_back(has_want ? want : pred);
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Waits for every owed result, then lets the pipeline settle.
    task automatic wait_idle();
        while (pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side. Normally it stalls in short random bursts; on request it
    // holds off for a long stretch so that the queue inside fills up and the
    // controller has to stall its own input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every accepted result is matched against the oldest owed one.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("result %p with nothing owed", o_out_data));
            end else begin
                want = pending_drives.pop_front();
                if (o_out_data.stop_event !== want.stop_event) begin
                    report_mismatch($sformatf("stop_event got %b want %b",
                                              o_out_data.stop_event, want.stop_event));
                end
                if (o_out_data.drive_left !== want.drive_left) begin
                    report_mismatch($sformatf("drive_left got %0d want %0d",
                                              o_out_data.drive_left, want.drive_left));
                end
                if (o_out_data.drive_right !== want.drive_right) begin
                    report_mismatch($sformatf("drive_right got %0d want %0d",
                                              o_out_data.drive_right, want.drive_right));
                end
            end
        end
    end

    initial begin
        t_in final_req;

        // Reset settings: a sample is on at 350 and above, off below 150.
        // The restart rows below therefore start from an empty history, and
        // with the reset gains any error of a few hundred saturates the
        // correction at plus or minus 150.
        directed_rows.push_back(dir_row(2000, 0, 0, 4095, 0, 0, 1, 1, 0, 150, 150));
        directed_rows.push_back(dir_row(0,    0, 0, 4095, 0, 0, 1, 1, 0, 0,   150));
        directed_rows.push_back(dir_row(4000, 0, 0, 4095, 0, 0, 1, 1, 0, 150, 0));
        // A position past 4000 is taken as is.
        directed_rows.push_back(dir_row(4095, 0, 0, 4095, 0, 0, 1, 1, 0, 150, 0));
        directed_rows.push_back(dir_row(4095, 0, 0, 4095, 0, 0, 0, 0, 0, 0,   0));
        // Outer sensors on: stop, history kept.
        directed_rows.push_back(dir_row(2000, 4095, 0, 4095, 0, 0, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(2000, 0, 0, 4095, 0, 4095, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(2000, 350, 0, 4095, 0, 0, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(2000, 0, 0, 4095, 0, 350, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(2000, 349, 0, 4095, 0, 349, 1, 1, 0, 150, 150));
        // Line lost: all three middle sensors off.
        directed_rows.push_back(dir_row(2100, 0, 149, 149, 149, 0, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(1900, 0, 150, 149, 149, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(2100, 0, 149, 149, 150, 0, 0, 0, 0, 0, 0));
        // Restart together with a stop still clears the history.
        directed_rows.push_back(dir_row(3000, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(2010, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(2000, 4095, 4095, 4095, 4095, 4095, 0, 1, 1, 0, 0));
        directed_rows.push_back(dir_row(1990, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(2000, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(1500, 0, 0, 0, 4095, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(2500, 0, 4095, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(0, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(4095, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].req, directed_rows[n].has_want,
                         directed_rows[n].want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_request(random_request(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // Random phases, each under its own register setting. Settings are
        // only changed once every owed result is back.
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0: load_settings(256, 0, 0, 255, 2048, 0);
                1: load_settings(0, 0, 0, 0, 4095, 0);
                2: load_settings('1, '1, '1, '1, 250, 100);
                // Deadzone wider than the threshold: no sample is ever off.
                3: load_settings($urandom_range(0, 4096), $urandom_range(0, 4096),
                                 $urandom_range(0, 4096), $urandom, 0, 4095);
                // Nothing is ever on and nothing ever off.
                4: load_settings($urandom, $urandom, $urandom, $urandom, 4095, 4095);
                // Every sample is on, so every request stops.
                5: load_settings($urandom, $urandom, $urandom, $urandom, 0, 0);
                default: load_settings($urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom_range(0, 600));
            endcase
            in_idle_en  = (phase == 1) || (phase == 2) || (phase >= 4 && phase != 6);
            out_idle_en = (phase == 1) || (phase == 3) || (phase >= 4 && phase != 6);
            // First phase: a long hold-off on the result side while requests
            // keep coming at full rate.
            hold_off_req = (phase == 0);
            for (int n = 0; n < ((phase == 5) ? 30 : RANDOM_ITEMS); n++) begin
                send_request(random_request(), 1'b0, '0);
            end
            i_in_valid <= 1'b0;
        end

        // Closing stream at full rate with no idling on either side. Only the
        // integral term acts, so the correction follows the growing error
        // sum; the final requests pull the sum back the other way.
        wait_idle();
        load_settings(0, 1, 0, 255, 250, 100);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        final_req = '0;
        final_req.line_pos      = POS_W'(4095);
        final_req.sample_middle = BRIGHT;
        final_req.sample_left   = DARK;
        final_req.restart       = 1'b1;
        for (int n = 0; n < FINAL_ITEMS + UNWIND_ITEMS; n++) begin
            if (n == FINAL_ITEMS) begin
                final_req.line_pos = '0;
            end
            send_request(final_req, 1'b0, '0);
            final_req.restart = 1'b0;
        end
        i_in_valid <= 1'b0;

        wait_idle();
        if (mismatch_count == 0) begin
            $display("pid_line_follow_controller_unit: match");
        end else begin
            $display("pid_line_follow_controller_unit: mismatch");
        end
        $finish;
    end

    // Watchdog: a run that has not finished by this time is reported as a mismatch.
    initial begin
        #2_000_000;
        $display("pid_line_follow_controller_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
sv/lfc_pkg.sv
sv/lfc_front.sv
sv/lfc_queue.sv
sv/lfc_back.sv
sv/pid_line_follow_controller_unit.sv
tb/tb_pid_line_follow_controller_unit.sv
